// ----- src/mnpt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note priority tracker - shared definitions
// Field widths, MIDI byte codes, stack geometry, pitch conversion and types.
// ----------------------------------------------------------------------------
package mnpt_pkg;

    // Port field widths
    localparam int BYTE_W    = 8;
    localparam int NOTE_W    = 7;
    localparam int PITCH_W   = 15;
    localparam int HELD_W    = 5;

    // Held-note stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // MIDI byte codes
    localparam logic [BYTE_W-1:0] REALTIME_MIN = 8'hF8;
    localparam logic [3:0]        NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0]        NIB_NOTE_ON  = 4'h9;

    // Pitch conversion
    localparam int NOTE_BASE      = 36;
    localparam int CENTS_PER_NOTE = 100;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_OFF  = 2'd1,
        CMD_ON   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
    } stack_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_PUSH,
        S_TOP,
        S_TOPW
    } state_t;

endpackage
`default_nettype wire

// ----- src/midi_note_priority_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI note priority tracker (last-note priority)
// Parses a raw MIDI byte stream, keeps a stack of held notes in a small
// synchronous RAM and reports the most recently pressed note still held.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   -------------------------------------
//  input     in_valid / in_ready    midi_byte (8)
//  output    out_valid / out_ready  pitch_cents (15, signed), velocity (7),
//                                   notes_held (5)
//
// Status bytes, real-time bytes and the note byte of a pair are taken while
// the sequencer stays idle. A velocity byte starts the stack sequencer: a push
// onto a stack with room writes the new top entry directly, a note release
// searches the entries downwards from the top and moves any entries above the
// match down, and a push onto a full stack first moves every entry down to drop
// the oldest. The sequencer works through the single read port of the stack
// RAM, whose read data is registered.
// Reset clears the control state and the stack count only; the RAM needs no
// clearing pass, as only entries below the count are ever read.
// A finished result waits in the output register, and a new request is taken
// meanwhile; the sequencer stalls only when the next result is ready and the
// output register is still full.
//
module midi_note_priority_tracker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [mnpt_pkg::BYTE_W-1:0]        midi_byte,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic signed [mnpt_pkg::PITCH_W-1:0] pitch_cents,
    output logic [mnpt_pkg::NOTE_W-1:0]        velocity,
    output logic [mnpt_pkg::HELD_W-1:0]        notes_held
);
    import mnpt_pkg::*;

    // Stack RAM: one write port and one read port with registered read data.
    stack_entry_t mem [STACK_DEPTH];
    stack_entry_t rd_data_reg;
    logic         rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic         wr_en;
    logic [IDX_W-1:0] wr_addr;
    stack_entry_t wr_data;

    // Sequencer and parser state
    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic              pend_reg, pend_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic [NOTE_W-1:0] vel_reg, vel_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  end_reg, end_next;
    logic              push_reg, push_next;
    logic signed [PITCH_W-1:0] last_pitch_reg, last_pitch_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next;
    logic [NOTE_W-1:0]         vel_out_reg, vel_out_next;
    logic [HELD_W-1:0]         held_reg, held_next;

    logic              in_take;
    logic              out_free;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_m2;
    logic signed [NOTE_W+1:0]   note_diff;
    logic signed [PITCH_W-1:0]  pitch_full;
    logic signed [PITCH_W-1:0]  top_pitch;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_take     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign pitch_cents = pitch_reg;
    assign velocity    = vel_out_reg;
    assign notes_held  = held_reg;

    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);

    // Pitch of the entry read from the top of the stack
    assign note_diff  = $signed({2'b00, rd_data_reg.note}) - (NOTE_W+2)'(NOTE_BASE);
    assign pitch_full = PITCH_W'(note_diff) * PITCH_W'(CENTS_PER_NOTE);
    assign top_pitch  = pitch_full;

    // Memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_NONE;
            pend_reg       <= 1'b0;
            note_reg       <= '0;
            count_reg      <= '0;
            last_pitch_reg <= '0;
            out_valid_reg  <= 1'b0;
            push_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            pend_reg       <= pend_next;
            note_reg       <= note_next;
            count_reg      <= count_next;
            last_pitch_reg <= last_pitch_next;
            out_valid_reg  <= out_valid_next;
            push_reg       <= push_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vel_reg     <= vel_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        pitch_reg   <= pitch_next;
        vel_out_reg <= vel_out_next;
        held_reg    <= held_next;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pend_next       = pend_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        push_next       = push_reg;
        last_pitch_next = last_pitch_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pitch_next      = pitch_reg;
        vel_out_next    = vel_out_reg;
        held_next       = held_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take && (midi_byte < REALTIME_MIN))
                begin
                    if (midi_byte[BYTE_W-1])
                    begin
                        // Status byte: only note on and note off keep data handling.
                        case (midi_byte[BYTE_W-1:BYTE_W-4])
                            NIB_NOTE_OFF: cmd_next = CMD_OFF;
                            NIB_NOTE_ON:  cmd_next = CMD_ON;
                            default:      cmd_next = CMD_NONE;
                        endcase
                        pend_next = 1'b0;
                    end
                    else if ((cmd_reg == CMD_OFF) || (cmd_reg == CMD_ON))
                    begin
                        if (!pend_reg)
                        begin
                            note_next = midi_byte[NOTE_W-1:0];
                            pend_next = 1'b1;
                        end
                        else
                        begin
                            pend_next = 1'b0;
                            vel_next  = midi_byte[NOTE_W-1:0];
                            push_next = 1'b0;
                            if ((cmd_reg == CMD_OFF) || (midi_byte[NOTE_W-1:0] == '0))
                            begin
                                // Release: search downwards from the top.
                                if (count_reg == '0)
                                begin
                                    state_next = S_TOP;
                                end
                                else
                                begin
                                    ptr_next   = count_m1[IDX_W-1:0];
                                    state_next = S_SCAN_RD;
                                end
                            end
                            else if (count_reg < CNT_W'(STACK_DEPTH))
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = count_reg[IDX_W-1:0];
                                wr_data.note = note_reg;
                                wr_data.vel  = midi_byte[NOTE_W-1:0];
                                count_next   = count_reg + CNT_W'(1);
                                state_next   = S_TOP;
                            end
                            else if (STACK_DEPTH == 1)
                            begin
                                state_next = S_PUSH;
                            end
                            else
                            begin
                                // Full: drop the oldest entry by moving all down.
                                push_next  = 1'b1;
                                ptr_next   = '0;
                                end_next   = IDX_W'(STACK_DEPTH - 2);
                                state_next = S_SH_RD;
                            end
                        end
                    end
                end
            end

            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (rd_data_reg.note == note_reg)
                begin
                    if (ptr_reg == count_m1[IDX_W-1:0])
                    begin
                        count_next = count_m1;
                        state_next = S_TOP;
                    end
                    else
                    begin
                        end_next   = count_m2[IDX_W-1:0];
                        state_next = S_SH_RD;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    ptr_next   = ptr_reg - IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg + IDX_W'(1);
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
                if (ptr_reg == end_reg)
                begin
                    if (push_reg)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        count_next = count_m1;
                        state_next = S_TOP;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = S_SH_RD;
                end
            end

            S_PUSH:
            begin
                wr_en        = 1'b1;
                wr_addr      = IDX_W'(STACK_DEPTH - 1);
                wr_data.note = note_reg;
                wr_data.vel  = vel_reg;
                count_next   = CNT_W'(STACK_DEPTH);
                state_next   = S_TOP;
            end

            S_TOP:
            begin
                if (count_reg == '0)
                begin
                    // Empty stack: hold the last pitch, report silence.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        pitch_next     = last_pitch_reg;
                        vel_out_next   = '0;
                        held_next      = HELD_W'(count_reg);
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = count_m1[IDX_W-1:0];
                    state_next = S_TOPW;
                end
            end

            S_TOPW:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    pitch_next      = top_pitch;
                    vel_out_next    = rd_data_reg.vel;
                    held_next       = HELD_W'(count_reg);
                    last_pitch_next = top_pitch;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The stack never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    // Only entries below the count are read from the stack RAM.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CNT_W'(rd_addr) < count_reg))
        else $error("read of an unused stack entry");

    // Reads and writes never meet on the same entry in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("read and write collide on one entry");

    // A new result is loaded only by the top-of-stack states.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_TOP || $past(state_reg) == S_TOPW))
        else $error("result loaded outside the report states");

    // The sequencer leaves idle only on an accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_take) |=> (state_reg == S_IDLE))
        else $error("sequencer started without a request");

endmodule
`default_nettype wire
